@@ src/kme_pkg.sv @@
// ----------------------------------------------------------------------------
// kme_pkg
// Shared types, constants and key tables of the key matrix event encoder.
// ----------------------------------------------------------------------------
package kme_pkg;

   localparam int NUM_ROWS    = 4;
   localparam int NUM_COLS    = 14;
   localparam int NUM_POS     = NUM_ROWS * NUM_COLS;
   localparam int NUM_SELECTS = 8;
   localparam int NUM_SENSE   = 7;

   localparam int SCAN_W = NUM_SELECTS * NUM_SENSE;
   localparam int CODE_W = 8;
   localparam int ROW_W  = 2;
   localparam int COL_W  = 4;
   localparam int POS_W  = 6;

   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(NUM_ROWS - 1);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(NUM_COLS - 1);

   // Modifier positions in physical row-major order
   localparam int SHIFT_POS = 2 * NUM_COLS + 1;
   localparam int CTRL_POS  = 3 * NUM_COLS + 0;
   localparam int FN_POS    = 2 * NUM_COLS + 0;

   localparam logic [CODE_W-1:0] CODE_NONE  = 8'h00;
   localparam logic [CODE_W-1:0] CODE_UP    = 8'h80;
   localparam logic [CODE_W-1:0] CODE_DOWN  = 8'h81;
   localparam logic [CODE_W-1:0] CODE_LEFT  = 8'h82;
   localparam logic [CODE_W-1:0] CODE_RIGHT = 8'h83;
   localparam logic [CODE_W-1:0] CTRL_MASK  = 8'h1f;

   localparam logic [CODE_W-1:0] CHR_LC_A = 8'h61;
   localparam logic [CODE_W-1:0] CHR_LC_Z = 8'h7a;
   localparam logic [CODE_W-1:0] CHR_UC_A = 8'h41;
   localparam logic [CODE_W-1:0] CHR_UC_Z = 8'h5a;

   localparam logic [CODE_W-1:0] PLAIN_TBL [0:NUM_POS-1] = '{
      8'h60, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h3d, 8'h08,
      8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79,
      8'h75, 8'h69, 8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h5c,
      8'h00, 8'h00, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67,
      8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b, 8'h27, 8'h0d,
      8'h00, 8'h00, 8'h00, 8'h7a, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6e, 8'h6d, 8'h2c, 8'h2e, 8'h2f, 8'h20
   };

   localparam logic [CODE_W-1:0] SHIFT_TBL [0:NUM_POS-1] = '{
      8'h7e, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e,
      8'h26, 8'h2a, 8'h28, 8'h29, 8'h5f, 8'h2b, 8'h08,
      8'h09, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59,
      8'h55, 8'h49, 8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h7c,
      8'h00, 8'h00, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47,
      8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a, 8'h22, 8'h0d,
      8'h00, 8'h00, 8'h00, 8'h5a, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h20
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH
   } walk_state_type;

   typedef struct packed {
      logic [CODE_W-1:0] key_code;
      logic              is_press;
      logic [ROW_W-1:0]  key_row;
      logic [COL_W-1:0]  key_column;
   } event_type;

   typedef struct packed {
      logic      push;
      logic      flush;
      event_type evt;
   } queue_ctl_type;

   typedef struct packed {
      logic push_ok;
      logic flush_ok;
   } queue_stat_type;

   // Reorder scan bits (select*7+column) into physical row-major order
   function automatic logic [NUM_POS-1:0] kme_to_phys(input logic [SCAN_W-1:0] bits);
      logic [NUM_POS-1:0] phys;
      phys = '0;
      for (int r = 0; r < NUM_ROWS; r++) begin
         for (int x = 0; x < NUM_COLS; x++) begin
            phys[r*NUM_COLS + x] =
               bits[((NUM_ROWS - 1 - r) + ((x % 2 == 0) ? NUM_ROWS : 0)) * NUM_SENSE + x / 2];
         end
      end
      return phys;
   endfunction

   function automatic logic [CODE_W-1:0] kme_resolve(
      input logic [ROW_W-1:0] row,
      input logic [COL_W-1:0] col,
      input logic             sh,
      input logic             ct,
      input logic             fn
   );
      logic [POS_W-1:0]  idx;
      logic [CODE_W-1:0] ch;
      logic [CODE_W-1:0] res;
      idx = POS_W'(row) * POS_W'(NUM_COLS) + POS_W'(col);
      ch  = CODE_NONE;
      if (idx < POS_W'(NUM_POS)) begin
         ch = sh ? SHIFT_TBL[idx] : PLAIN_TBL[idx];
      end
      if (ct && ((ch >= CHR_LC_A && ch <= CHR_LC_Z) || (ch >= CHR_UC_A && ch <= CHR_UC_Z))) begin
         ch = ch & CTRL_MASK;
      end
      res = ch;
      if (fn) begin
         if (row == 2'd2 && col == 4'd11) begin
            res = CODE_UP;
         end else if (row == 2'd3 && col == 4'd11) begin
            res = CODE_DOWN;
         end else if (row == 2'd3 && col == 4'd10) begin
            res = CODE_LEFT;
         end else if (row == 2'd3 && col == 4'd12) begin
            res = CODE_RIGHT;
         end
      end
      return res;
   endfunction

endpackage

@@ src/kme_intf.sv @@
// ----------------------------------------------------------------------------
// kme_req_if / kme_rsp_if
// Valid/ready channels for scan requests and key events.
// ----------------------------------------------------------------------------
interface kme_req_if;
   import kme_pkg::*;

   logic              valid;
   logic              ready;
   logic [SCAN_W-1:0] scan_bits;

   modport source (output valid, output scan_bits, input ready);
   modport sink   (input valid, input scan_bits, output ready);
endinterface

interface kme_rsp_if;
   import kme_pkg::*;

   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] key_code;
   logic              is_press;
   logic [ROW_W-1:0]  key_row;
   logic [COL_W-1:0]  key_column;
   logic              last;

   modport source (output valid, output key_code, output is_press, output key_row,
                   output key_column, output last, input ready);
   modport sink   (input valid, input key_code, input is_press, input key_row,
                   input key_column, input last, output ready);
endinterface

@@ src/key_matrix_event_encoder_core.sv @@
// ----------------------------------------------------------------------------
// key_matrix_event_encoder_core
// Turns full 56-key matrix scans into key press and release events.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan takes one scan (56 bits, select*7+column) per request. rsp_chan
//   returns zero to 56 events for it, in physical row-major order, with last
//   set on the final event of the scan. A scan that changes nothing visible
//   returns no events.
//   Each scan walks all 56 key positions one per cycle while the receiver
//   keeps up, through a bit-serial ring of the scan, the pressed map and the
//   held codes. A scan occupies the block for an accept, the walk over all
//   positions and a flush that releases the final event. The final event
//   moves to the output register in the flush after the walk ends; each other
//   event leaves when the next event of the scan is found.
//   When the receiver stalls, the walk holds at a position that has a new
//   event while one event waits in the output register and one is held back.
//   The next scan is accepted as soon as the last event of the previous scan
//   is in the output register, even if it has not yet been taken.
//   Reset clears the pressed map and held codes at once and drops any
//   pending event; the block is ready in the cycle after reset.
// ----------------------------------------------------------------------------
module key_matrix_event_encoder_core (
   input  logic      clock,
   input  logic      reset,
   kme_req_if.sink   req_chan,
   kme_rsp_if.source rsp_chan
);
   import kme_pkg::*;

   queue_ctl_type  q_ctl;
   queue_stat_type q_stat;
   event_type      rsp_evt;

   kme_scan_walker u_walker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_scan_bits (req_chan.scan_bits),
      .q_ctl         (q_ctl),
      .q_stat        (q_stat)
   );

   kme_event_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .q_ctl     (q_ctl),
      .q_stat    (q_stat),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_evt   (rsp_evt),
      .rsp_last  (rsp_chan.last)
   );

   assign rsp_chan.key_code   = rsp_evt.key_code;
   assign rsp_chan.is_press   = rsp_evt.is_press;
   assign rsp_chan.key_row    = rsp_evt.key_row;
   assign rsp_chan.key_column = rsp_evt.key_column;

endmodule

@@ src/kme_scan_walker.sv @@
// ----------------------------------------------------------------------------
// kme_scan_walker
// Shifts one scan through the key positions a bit per cycle unless the queue
// is full, rotating pressed map and held codes in step, and pushes key events.
// ----------------------------------------------------------------------------
module kme_scan_walker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [kme_pkg::SCAN_W-1:0] req_scan_bits,
   output kme_pkg::queue_ctl_type  q_ctl,
   input  kme_pkg::queue_stat_type q_stat
);
   import kme_pkg::*;

   walk_state_type state_ff, state_in;

   logic [NUM_POS-1:0] scan_ff, scan_in;
   logic [NUM_POS-1:0] pressed_ff, pressed_in;
   logic [CODE_W-1:0]  held_ff [NUM_POS];
   logic [CODE_W-1:0]  held_in [NUM_POS];
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic               sh_ff, sh_in;
   logic               ct_ff, ct_in;
   logic               fn_ff, fn_in;

   logic               walk_en;
   logic               flush_en;
   logic               accept;
   logic [NUM_POS-1:0] phys;
   logic               cur_bit;
   logic               changed;
   logic [CODE_W-1:0]  press_code;
   logic [CODE_W-1:0]  old_code;
   logic               emit;
   logic               step;
   logic               last_pos;
   logic [CODE_W-1:0]  new_code;

   // State outputs
   always_comb begin
      req_ready = 1'b0;
      walk_en   = 1'b0;
      flush_en  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_WALK:  walk_en   = 1'b1;
         ST_FLUSH: flush_en  = 1'b1;
         default:  req_ready = 1'b0;
      endcase
   end

   assign accept = req_valid && req_ready;
   assign phys   = kme_to_phys(req_scan_bits);

   always_comb begin
      cur_bit    = scan_ff[0];
      old_code   = held_ff[0];
      changed    = cur_bit ^ pressed_ff[0];
      press_code = kme_resolve(row_ff, col_ff, sh_ff, ct_ff, fn_ff);
      emit       = changed && (cur_bit ? (press_code != CODE_NONE) : (old_code != CODE_NONE));
      step       = walk_en && (!emit || q_stat.push_ok);
      last_pos   = (row_ff == ROW_LAST) && (col_ff == COL_LAST);
      // store a resolved press, clear on release, otherwise keep
      if (changed && cur_bit && press_code != CODE_NONE) begin
         new_code = press_code;
      end else if (changed && !cur_bit) begin
         new_code = CODE_NONE;
      end else begin
         new_code = old_code;
      end
   end

   always_comb begin
      q_ctl.push                = step && emit;
      q_ctl.flush               = flush_en;
      q_ctl.evt.key_code        = cur_bit ? press_code : old_code;
      q_ctl.evt.is_press        = cur_bit;
      q_ctl.evt.key_row         = row_ff;
      q_ctl.evt.key_column      = col_ff;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (step && last_pos) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (q_stat.flush_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath next values
   always_comb begin
      scan_in    = scan_ff;
      pressed_in = pressed_ff;
      held_in    = held_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      sh_in      = sh_ff;
      ct_in      = ct_ff;
      fn_in      = fn_ff;
      if (accept) begin
         scan_in = phys;
         sh_in   = phys[SHIFT_POS];
         ct_in   = phys[CTRL_POS];
         fn_in   = phys[FN_POS];
         row_in  = '0;
         col_in  = '0;
      end else if (step) begin
         // advance all three rings by one position
         scan_in    = {1'b0, scan_ff[NUM_POS-1:1]};
         pressed_in = {cur_bit, pressed_ff[NUM_POS-1:1]};
         for (int i = 0; i < NUM_POS - 1; i++) begin
            held_in[i] = held_ff[i+1];
         end
         held_in[NUM_POS-1] = new_code;
         if (col_ff == COL_LAST) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pressed_ff <= '0;
         for (int i = 0; i < NUM_POS; i++) begin
            held_ff[i] <= CODE_NONE;
         end
         row_ff     <= '0;
         col_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         pressed_ff <= pressed_in;
         held_ff    <= held_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      sh_ff   <= sh_in;
      ct_ff   <= ct_in;
      fn_ff   <= fn_in;
   end

endmodule

@@ src/kme_event_queue.sv @@
// ----------------------------------------------------------------------------
// kme_event_queue
// Holds one event back until the next one or the end of the scan shows
// whether it is the last, then presents it in the output register.
// ----------------------------------------------------------------------------
module kme_event_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  kme_pkg::queue_ctl_type  q_ctl,
   output kme_pkg::queue_stat_type q_stat,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output kme_pkg::event_type      rsp_evt,
   output logic                    rsp_last
);
   import kme_pkg::*;

   logic      pend_valid_ff, pend_valid_in;
   event_type pend_ff, pend_in;
   logic      out_valid_ff, out_valid_in;
   event_type out_ff, out_in;
   logic      last_ff, last_in;
   logic      out_free;

   assign out_free        = !out_valid_ff || rsp_ready;
   assign q_stat.push_ok  = !pend_valid_ff || out_free;
   assign q_stat.flush_ok = !pend_valid_ff || out_free;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_in        = out_ff;
      last_in       = last_ff;
      if (q_ctl.push) begin
         // older event is not the last: a newer one follows
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = pend_ff;
            last_in      = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_in       = q_ctl.evt;
      end else if (q_ctl.flush && pend_valid_ff && out_free) begin
         out_valid_in  = 1'b1;
         out_in        = pend_ff;
         last_in       = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      out_ff  <= out_in;
      last_ff <= last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_evt   = out_ff;
   assign rsp_last  = last_ff;

endmodule

@@ src/kme_checker.sv @@
// ----------------------------------------------------------------------------
// kme_checker
// Port-level checks of the key matrix event encoder, bound to the top level.
// ----------------------------------------------------------------------------
module kme_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [kme_pkg::CODE_W-1:0] rsp_key_code,
   input logic                       rsp_is_press,
   input logic [kme_pkg::ROW_W-1:0]  rsp_key_row,
   input logic [kme_pkg::COL_W-1:0]  rsp_key_column,
   input logic                       rsp_last
);
   import kme_pkg::*;

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_key_code)
         && $stable(rsp_is_press) && $stable(rsp_key_row)
         && $stable(rsp_key_column) && $stable(rsp_last))
      else $error("stalled response changed");

   a_no_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_key_code != CODE_NONE)
      else $error("event with zero key code");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_key_column <= COL_LAST)
      else $error("key column out of range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new request taken during a scan walk");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind key_matrix_event_encoder_core kme_checker u_kme_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_key_code   (rsp_chan.key_code),
   .rsp_is_press   (rsp_chan.is_press),
   .rsp_key_row    (rsp_chan.key_row),
   .rsp_key_column (rsp_chan.key_column),
   .rsp_last       (rsp_chan.last)
);
